// ===== rtl/core/eck3_pkg.sv =====
// Shared types, constants and helper functions of the Eckert III projection block.
package eck3_pkg;

	localparam int FRAC_BITS = 28;
	localparam int COORD_W = 32;
	localparam int MAG_W = 34;

	localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

	// Converts a decimal fraction d / 10^18 to an unsigned Q30 value, rounded to nearest.
	function automatic logic [63:0] dec_to_q30(input logic [63:0] d);
		logic [63:0] acc;
		logic [63:0] rem;
		acc = d / DEC_ONE;
		rem = d % DEC_ONE;
		for (int i = 0; i < 30; i++) begin
			acc = acc << 1;
			rem = rem << 1;
			if (rem >= DEC_ONE) begin
				acc = acc | 64'd1;
				rem = rem - DEC_ONE;
			end
		end
		if ((rem << 1) >= DEC_ONE) begin
			acc = acc + 64'd1;
		end
		return acc;
	endfunction

	localparam logic [63:0] HP_Q30_64 = dec_to_q30(64'd1570796326794896619);
	localparam logic [30:0] HP_Q30 = HP_Q30_64[30:0];
	localparam logic [29:0] HP_HALF = HP_Q30[30:1];
	localparam logic [61:0] HP_SQ = 62'(HP_Q30_64 * HP_Q30_64);
	// Reciprocal of pi/2 scaled by 2^32, truncated; it fits in 32 bits.
	localparam logic [63:0] HP_RECIP_64 = (64'd1 << 62) / HP_Q30_64;
	localparam logic [31:0] HP_RECIP = HP_RECIP_64[31:0];
	localparam logic [63:0] XF_Q30_64 = dec_to_q30(64'd422238200315771201);
	localparam logic [63:0] YF_Q30_64 = dec_to_q30(64'd844476400631542403);
	localparam logic [63:0] RXF_Q30_64 = dec_to_q30(64'd2368331428213148738);
	localparam logic [63:0] RYF_Q30_64 = dec_to_q30(64'd1184165714106574369);
	localparam logic [31:0] XF_Q30 = XF_Q30_64[31:0];
	localparam logic [31:0] YF_Q30 = YF_Q30_64[31:0];
	localparam logic [31:0] RXF_Q30 = RXF_Q30_64[31:0];
	localparam logic [31:0] RYF_Q30 = RYF_Q30_64[31:0];

	typedef enum logic {
		DIR_FORWARD = 1'b0,
		DIR_INVERSE = 1'b1
	} dir_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_first;
		logic signed [COORD_W-1:0] coord_second;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_first;
		logic signed [COORD_W-1:0] result_second;
		logic saturated;
	} res_t;

	typedef struct packed {
		logic advance;
		logic in_valid;
		dir_t dir;
	} pipe_ctl_t;

endpackage

// ===== rtl/core/eck3_ifs.sv =====
// Channel interfaces of the Eckert III projection block.
interface eck3_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] coord_first;
	logic signed [31:0] coord_second;
	modport source(output valid, coord_first, coord_second, input ready);
	modport sink(input valid, coord_first, coord_second, output ready);
endinterface

interface eck3_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] result_first;
	logic signed [31:0] result_second;
	logic saturated;
	modport source(output valid, result_first, result_second, saturated, input ready);
	modport sink(input valid, result_first, result_second, saturated, output ready);
endinterface

interface eck3_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source(output valid, direction, input ready);
	modport sink(input valid, direction, output ready);
endinterface

// ===== rtl/core/eck3_pipe.sv =====
// Arithmetic pipeline of the Eckert III projection: root, growth factor, divide and pack.
module eck3_pipe import eck3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pipe_ctl_t  ctl,
	input  item_t      in_item,
	output logic       out_valid,
	output res_t       out_res
);

	localparam int ST_IN = 0;
	localparam int ST_MUL = 1;
	localparam int ST_PSEL = 2;
	localparam int ST_SQ = 3;
	localparam int ST_DIFF = 4;
	localparam int SQRT_N = 31;
	localparam int SQRT_FIRST = 5;
	localparam int ST_GM = SQRT_FIRST + SQRT_N;
	localparam int ST_GR = ST_GM + 1;
	localparam int ST_GC = ST_GR + 1;
	localparam int ST_G1 = ST_GC + 1;
	localparam int ST_G2 = ST_G1 + 1;
	localparam int DIV_N = 33;
	localparam int DIV_FIRST = ST_G2 + 1;
	localparam int NST = DIV_FIRST + DIV_N;

	typedef struct packed {
		dir_t        dir;
		logic        a_neg;
		logic        b_neg;
		logic [31:0] a_mag;
		logic [31:0] b_mag;
		logic [63:0] mul_a;
		logic [63:0] mul_b;
		logic        lt;
		logic [30:0] p;
		logic [MAG_W-1:0] m1;
		logic [MAG_W-1:0] m2;
		logic [61:0] sqd;
		logic [32:0] srem;
		logic [30:0] root;
		logic [32:0] grem;
		logic [30:0] gq;
		logic [31:0] g;
		logic [31:0] k;
		logic [62:0] num;
		logic [31:0] drem;
		logic [32:0] dq;
	} pl_t;

	function automatic logic [63:0] rnd_shr(input logic [63:0] v, input int s);
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic pl_t f_in(input item_t it, input dir_t d);
		pl_t r;
		logic [31:0] ua;
		logic [31:0] ub;
		r = '0;
		ua = it.coord_first;
		ub = it.coord_second;
		r.dir = d;
		r.a_neg = ua[31];
		r.b_neg = ub[31];
		r.a_mag = ua[31] ? (~ua + 32'd1) : ua;
		r.b_mag = ub[31] ? (~ub + 32'd1) : ub;
		return r;
	endfunction

	function automatic pl_t f_mul(input pl_t x);
		pl_t r;
		r = x;
		r.mul_a = 64'(x.a_mag) * 64'((x.dir == DIR_INVERSE) ? RXF_Q30 : YF_Q30);
		r.mul_b = 64'(x.b_mag) * 64'(RYF_Q30);
		return r;
	endfunction

	function automatic pl_t f_psel(input pl_t x);
		pl_t r;
		logic [63:0] pw;
		r = x;
		if (x.dir == DIR_INVERSE) begin
			pw = rnd_shr(x.mul_b, FRAC_BITS);
			r.m1 = MAG_W'(rnd_shr(x.mul_b, 30));
			r.m2 = '0;
		end else begin
			pw = 64'(x.a_mag) << (30 - FRAC_BITS);
			r.m1 = '0;
			r.m2 = MAG_W'(rnd_shr(x.mul_a, 30));
		end
		r.lt = pw < 64'(HP_Q30);
		r.p = pw[30:0];
		return r;
	endfunction

	function automatic pl_t f_sq(input pl_t x);
		pl_t r;
		r = x;
		r.sqd = x.lt ? (62'(x.p) * 62'(x.p)) : HP_SQ;
		return r;
	endfunction

	function automatic pl_t f_diff(input pl_t x);
		pl_t r;
		r = x;
		r.sqd = HP_SQ - x.sqd;
		r.srem = '0;
		r.root = '0;
		return r;
	endfunction

	// One result bit of the integer square root per stage.
	function automatic pl_t f_sqrt(input pl_t x);
		pl_t r;
		logic [34:0] rem2;
		logic [34:0] trial;
		r = x;
		rem2 = {x.srem, x.sqd[61:60]};
		trial = {2'b00, x.root, 2'b01};
		if (rem2 >= trial) begin
			rem2 = rem2 - trial;
			r.root = {x.root[29:0], 1'b1};
		end else begin
			r.root = {x.root[29:0], 1'b0};
		end
		r.srem = rem2[32:0];
		r.sqd = {x.sqd[59:0], 2'b00};
		return r;
	endfunction

	// Quotient estimate of {root, pi/4} over pi/2 from the reciprocal; it is low by at most one.
	function automatic pl_t f_gmul(input pl_t x);
		pl_t r;
		logic [62:0] pr;
		r = x;
		pr = 63'(x.root) * 63'(HP_RECIP);
		r.gq = pr[62:32];
		return r;
	endfunction

	// Remainder of the estimate; it is below 2^32, so 33 low bits hold it exactly.
	function automatic pl_t f_grem(input pl_t x);
		pl_t r;
		logic [32:0] num_lo;
		logic [61:0] qh;
		r = x;
		num_lo = {x.root[2:0], HP_HALF};
		qh = 62'(x.gq) * 62'(HP_Q30);
		r.grem = num_lo - qh[32:0];
		return r;
	endfunction

	function automatic pl_t f_gcorr(input pl_t x);
		pl_t r;
		r = x;
		if (x.grem >= 33'(HP_Q30)) begin
			r.gq = x.gq + 31'd1;
		end
		return r;
	endfunction

	function automatic pl_t f_g1(input pl_t x);
		pl_t r;
		logic [31:0] g;
		logic [63:0] kw;
		r = x;
		g = x.lt ? (32'h4000_0000 + 32'(x.gq)) : 32'h4000_0000;
		kw = rnd_shr(64'(XF_Q30) * 64'(g), 30);
		r.g = g;
		r.k = kw[31:0];
		r.num = 63'(x.mul_a + 64'(g >> 1));
		r.drem = 32'(r.num[62:33]);
		r.dq = '0;
		return r;
	endfunction

	function automatic pl_t f_g2(input pl_t x);
		pl_t r;
		r = x;
		if (x.dir == DIR_FORWARD) begin
			r.m1 = MAG_W'(rnd_shr(64'(x.b_mag) * 64'(x.k), 30));
		end
		return r;
	endfunction

	// Restoring division of the inverse numerator by the growth factor.
	function automatic pl_t f_div(input pl_t x);
		pl_t r;
		logic [32:0] rem2;
		r = x;
		rem2 = {x.drem, x.num[32]};
		if (rem2 >= 33'(x.g)) begin
			rem2 = rem2 - 33'(x.g);
			r.dq = {x.dq[31:0], 1'b1};
		end else begin
			r.dq = {x.dq[31:0], 1'b0};
		end
		r.drem = rem2[31:0];
		r.num = {x.num[61:0], 1'b0};
		return r;
	endfunction

	function automatic logic [31:0] f_pack(input logic [MAG_W-1:0] mag, input logic neg,
		output logic sat);
		logic [31:0] v;
		sat = 1'b0;
		if (neg) begin
			if (mag > MAG_W'(34'h0_8000_0000)) begin
				sat = 1'b1;
				v = 32'h8000_0000;
			end else begin
				v = ~mag[31:0] + 32'd1;
			end
		end else begin
			if (mag > MAG_W'(34'h0_7FFF_FFFF)) begin
				sat = 1'b1;
				v = 32'h7FFF_FFFF;
			end else begin
				v = mag[31:0];
			end
		end
		return v;
	endfunction

	pl_t  pl_s [NST];
	pl_t  nx   [NST];
	logic vld_s [NST];

	for (genvar gi = 0; gi < NST; gi++) begin : g_stage
		if (gi == ST_IN) begin : g_in
			always_comb nx[gi] = f_in(in_item, ctl.dir);
		end else if (gi == ST_MUL) begin : g_mul
			always_comb nx[gi] = f_mul(pl_s[gi-1]);
		end else if (gi == ST_PSEL) begin : g_psel
			always_comb nx[gi] = f_psel(pl_s[gi-1]);
		end else if (gi == ST_SQ) begin : g_sq
			always_comb nx[gi] = f_sq(pl_s[gi-1]);
		end else if (gi == ST_DIFF) begin : g_diff
			always_comb nx[gi] = f_diff(pl_s[gi-1]);
		end else if (gi < ST_GM) begin : g_sqrt
			always_comb nx[gi] = f_sqrt(pl_s[gi-1]);
		end else if (gi == ST_GM) begin : g_gmul
			always_comb nx[gi] = f_gmul(pl_s[gi-1]);
		end else if (gi == ST_GR) begin : g_grem
			always_comb nx[gi] = f_grem(pl_s[gi-1]);
		end else if (gi == ST_GC) begin : g_gcorr
			always_comb nx[gi] = f_gcorr(pl_s[gi-1]);
		end else if (gi == ST_G1) begin : g_g1
			always_comb nx[gi] = f_g1(pl_s[gi-1]);
		end else if (gi == ST_G2) begin : g_g2
			always_comb nx[gi] = f_g2(pl_s[gi-1]);
		end else begin : g_div
			always_comb nx[gi] = f_div(pl_s[gi-1]);
		end

		if (gi == 0) begin : g_v0
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[gi] <= 1'b0;
				end else if (ctl.advance) begin
					vld_s[gi] <= ctl.in_valid;
				end
			end
		end else begin : g_vn
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[gi] <= 1'b0;
				end else if (ctl.advance) begin
					vld_s[gi] <= vld_s[gi-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.advance) begin
				pl_s[gi] <= nx[gi];
			end
		end
	end

	logic [MAG_W-1:0] last_m2;
	logic sat_first;
	logic sat_second;

	always_comb begin
		last_m2 = (pl_s[NST-1].dir == DIR_INVERSE) ? MAG_W'(pl_s[NST-1].dq) : pl_s[NST-1].m2;
		out_res.result_first = f_pack(pl_s[NST-1].m1, pl_s[NST-1].b_neg, sat_first);
		out_res.result_second = f_pack(last_m2, pl_s[NST-1].a_neg, sat_second);
		out_res.saturated = sat_first | sat_second;
	end

	assign out_valid = vld_s[NST-1];

endmodule

// ===== rtl/core/eckert3_projection.sv =====
// Top level of the Eckert III projection block: channels, direction register, output skid.
//
// The block takes coordinate pairs in signed Q4.28 on the in_ch channel and returns
// one result pair on out_ch for every transaction, in the same order. The cfg channel
// writes the direction bit: 0 maps latitude and longitude to the plane, 1 maps the
// plane back to latitude and longitude. Direction is sampled as each item enters.
// In both directions the block forms an integer square root, settled one bit per stage,
// and divides that root by the constant pi/2 with a reciprocal multiplication and one
// correction step; the inverse then divides by the growth factor, one bit per stage.
// Both directions pass through the same 74-stage pipeline on the way to out_ch, and
// throughput is one transaction per cycle, with no gaps between items, as long as
// the skid register stays empty and the pipeline is free to advance.
// When the receiver holds off, the output register keeps its result and a single
// skid register catches the item leaving the pipeline; once the skid register is full
// the whole pipeline freezes and in_ch.ready falls until the output is taken again.
// Reset clears every valid bit and sets the direction to forward; no clearing pass is
// needed. The saturated flag reports that either result was clamped to 32 bits.
module eckert3_projection import eck3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	eck3_in_if.sink           in_ch,
	eck3_out_if.source        out_ch,
	eck3_cfg_if.sink          cfg
);

	dir_t      direction_q;
	pipe_ctl_t ctl;
	item_t     in_item;
	logic      core_valid;
	res_t      core_res;
	logic      out_valid_q;
	res_t      out_res_q;
	logic      skid_valid_q;
	res_t      skid_res_q;
	logic      produce;
	logic      out_free;

	// Configuration writes are always taken; only bit 0 carries meaning.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FORWARD;
		end else if (cfg.valid) begin
			direction_q <= dir_t'(cfg.direction);
		end
	end

	// The pipeline moves whenever the skid register is empty, so ready depends on
	// registered state only and never on out_ch.ready.
	always_comb begin
		ctl.advance = !skid_valid_q;
		ctl.in_valid = in_ch.valid;
		ctl.dir = direction_q;
		in_item.coord_first = in_ch.coord_first;
		in_item.coord_second = in_ch.coord_second;
	end

	assign in_ch.ready = ctl.advance;

	eck3_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_item   (in_item),
		.out_valid (core_valid),
		.out_res   (core_res)
	);

	assign produce = core_valid & ctl.advance;
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (produce) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_res_q <= skid_res_q;
			end
		end else if (produce) begin
			if (out_free) begin
				out_res_q <= core_res;
			end else begin
				skid_res_q <= core_res;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.result_first = out_res_q.result_first;
	assign out_ch.result_second = out_res_q.result_second;
	assign out_ch.saturated = out_res_q.saturated;

	// The skid register is only ever filled behind a waiting output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output is empty");

	// A full skid register must freeze the input side.
	a_skid_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !in_ch.ready)
		else $error("input accepted while the skid register is full");

	// An item leaving the pipeline into a stalled output lands in the skid register.
	a_stall_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && out_valid_q && !out_ch.ready) |=> skid_valid_q)
		else $error("pipeline result lost behind a stalled output");

	// A result taken with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ch.ready && !skid_valid_q && !produce) |=> !out_valid_q)
		else $error("result repeated after its transaction");

endmodule

// ===== verif/eckert3_projection_tb.sv =====
// Self-checking testbench of the Eckert III projection block: random and directed coordinate pairs.
`timescale 1ns / 1ps

module eckert3_projection_tb;
	import eck3_pkg::*;

	// Scoreboard: it predicts each result from the accepted pair and the current
	// direction, holds the predictions in order and checks the results against them.
	class projection_scoreboard;
		res_t pending_results[$];
		int error_count;
		int checked_count;

		function new();
			error_count = 0;
			checked_count = 0;
		endfunction

		// Rounds v / 2^s to nearest, ties away from zero (v is a magnitude).
		static function logic [63:0] rshift_round(logic [63:0] v, int s);
			return (v + (64'd1 << (s - 1))) >> s;
		endfunction

		static function logic [63:0] floor_root(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] probe;
			root = 0;
			probe = 64'd1 << 62;
			while (probe > v) probe = probe >> 2;
			while (probe != 0) begin
				if (v >= root + probe) begin
					v = v - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			return root;
		endfunction

		// Q30 factor 1 + sqrt(1 - (p/hp)^2); exactly one at and beyond the pole.
		static function logic [63:0] widening_q30(logic [63:0] p30);
			logic [63:0] hp;
			logic [63:0] r;
			hp = HP_Q30_64;
			if (p30 >= hp) return 64'd1 << 30;
			r = floor_root(hp * hp - p30 * p30);
			return (((hp + r) << 30) + hp / 2) / hp;
		endfunction

		// Applies the sign to a magnitude and clamps it to 32 bits.
		static function logic [31:0] apply_sign(logic [63:0] mag, logic neg, ref logic sat);
			if (neg) begin
				if (mag > (64'd1 << 31)) begin
					mag = 64'd1 << 31;
					sat = 1'b1;
				end
				return 32'(64'd0 - mag);
			end
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
				sat = 1'b1;
			end
			return mag[31:0];
		endfunction

		static function res_t project_pair(dir_t dir, item_t item);
			res_t res;
			logic [63:0] a_mag, b_mag, g30, k30, m1, m2, p30, prod_x, prod_y;
			logic a_neg, b_neg, sat;
			sat = 1'b0;
			a_neg = item.coord_first[31];
			b_neg = item.coord_second[31];
			a_mag = a_neg ? (64'd1 << 32) - {32'd0, item.coord_first}
				: {32'd0, item.coord_first};
			b_mag = b_neg ? (64'd1 << 32) - {32'd0, item.coord_second}
				: {32'd0, item.coord_second};
			if (dir == DIR_FORWARD) begin
				p30 = a_mag << (30 - FRAC_BITS);
				g30 = widening_q30(p30);
				k30 = rshift_round(XF_Q30_64 * g30, 30);
				m1 = rshift_round(b_mag * k30, 30);
				m2 = rshift_round(a_mag * YF_Q30_64, 30);
			end else begin
				prod_y = b_mag * RYF_Q30_64;
				prod_x = a_mag * RXF_Q30_64;
				p30 = rshift_round(prod_y, FRAC_BITS);
				g30 = widening_q30(p30);
				m1 = rshift_round(prod_y, 30);
				m2 = (prod_x + g30 / 2) / g30;
			end
			res.result_first = apply_sign(m1, b_neg, sat);
			res.result_second = apply_sign(m2, a_neg, sat);
			res.saturated = sat;
			return res;
		endfunction

		function void note_pair(dir_t dir, item_t item);
			pending_results.push_back(project_pair(dir, item));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result arrived with no prediction waiting");
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			checked_count++;
			if (got.result_first !== want.result_first) begin
				$error("result_first: expected %0d, got %0d", want.result_first, got.result_first);
				error_count++;
			end
			if (got.result_second !== want.result_second) begin
				$error("result_second: expected %0d, got %0d", want.result_second,
					got.result_second);
				error_count++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
				error_count++;
			end
		endfunction
	endclass

	localparam int LATENCY = 74;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PAIRS = 1200;

	logic clk;
	logic arst_n;

	eck3_in_if in_ch();
	eck3_out_if out_ch();
	eck3_cfg_if cfg();

	eckert3_projection dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	projection_scoreboard board;
	dir_t current_dir;
	int idle_cycles;
	logic timed_out;
	int sat_seen;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: every transaction on out_ch is checked against the oldest
	// prediction. Ready follows a pattern of its own: long open stretches mixed
	// with runs of random stalls, so that the skid register gets exercised.
	int stall_phase;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				res_t got;
				got.result_first = out_ch.result_first;
				got.result_second = out_ch.result_second;
				got.saturated = out_ch.saturated;
				if (got.saturated) sat_seen++;
				board.check_result(got);
			end
			stall_phase = (stall_phase + 1) % 400;
			if (stall_phase < 120) out_ch.ready <= 1'b1;
			else if (stall_phase < 200) out_ch.ready <= ($urandom_range(0, 3) != 0);
			else out_ch.ready <= $urandom_range(0, 1);
		end
	end

	// Watchdog: counts cycles in which no transaction happens on any channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired with %0d results outstanding",
				board.pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Writes the direction register through its channel; only called while idle.
	task automatic write_direction(dir_t dir);
		cfg.valid <= 1'b1;
		cfg.direction <= dir;
		do @(posedge clk); while (!cfg.ready);
		current_dir = dir;
		cfg.valid <= 1'b0;
	endtask

	// Offers one pair and holds it until the transaction completes.
	task automatic send_pair(logic [31:0] first, logic [31:0] second);
		item_t item;
		item.coord_first = first;
		item.coord_second = second;
		in_ch.valid <= 1'b1;
		in_ch.coord_first <= first;
		in_ch.coord_second <= second;
		do @(posedge clk); while (!in_ch.ready);
		board.note_pair(current_dir, item);
	endtask

	task automatic pause_sender(int cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off until every prediction has been met, then lets the pipeline drain.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Random field value biased towards the interesting regions: near the poles
	// (pi/2 is about 0x1921FB54 in Q4.28), near zero, extremes and full range.
	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'h1921_FB54 + $urandom_range(0, 64) - 32;
			1: v = $urandom_range(0, 32'h1921_FB54);
			2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
				: 32'h8000_0000 + $urandom_range(0, 3);
			3: v = $urandom_range(0, 255);
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	// Directed pairs: field extremes, zero, just inside, on and beyond the pole,
	// and inputs large enough to saturate the inverse mapping.
	task automatic send_directed();
		send_pair(32'h0000_0000, 32'h0000_0000);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF);
		send_pair(32'h1921_FB54, 32'h1000_0000);
		send_pair(32'h1921_FB53, 32'hF000_0000);
		send_pair(32'h1921_FB55, 32'h3243_F6A9);
		send_pair(32'hE6DE_04AC, 32'hCDBC_0957);
		send_pair(32'h0000_0001, 32'hFFFF_FFFF);
		send_pair(32'h1555_5555, 32'h5555_5555);
		send_pair(32'h6000_0000, 32'hA000_0000);
		send_pair(32'hFFFF_FFFF, 32'h0000_0001);
	endtask

	task automatic send_random(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && count > 0) begin
				send_pair(pick_coord(), pick_coord());
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
		end
	endtask

	initial begin
		board = new();
		current_dir = DIR_FORWARD;
		idle_cycles = 0;
		timed_out = 1'b0;
		sat_seen = 0;
		stall_phase = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.coord_first = '0;
		in_ch.coord_second = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.direction = DIR_FORWARD;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Forward at reset value, then both directions explicitly, several times.
		send_directed();
		wait_drained();
		write_direction(DIR_INVERSE);
		send_directed();
		wait_drained();
		write_direction(DIR_FORWARD);
		send_random(RANDOM_PAIRS / 4);
		wait_drained();
		write_direction(DIR_INVERSE);
		send_random(RANDOM_PAIRS / 4);
		wait_drained();
		write_direction(DIR_FORWARD);
		send_random(RANDOM_PAIRS / 4);
		wait_drained();
		write_direction(DIR_INVERSE);
		send_random(RANDOM_PAIRS / 4);
		wait_drained();

		if (board.pending_results.size() != 0) begin
			$error("%0d predictions never met", board.pending_results.size());
			board.error_count++;
		end
		$display("Checked %0d results over both directions, %0d of them clamped.",
			board.checked_count, sat_seen);
		if (board.error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== eckert3_projection.f =====
rtl/core/eck3_pkg.sv
rtl/core/eck3_ifs.sv
rtl/core/eck3_pipe.sv
rtl/core/eckert3_projection.sv
verif/eckert3_projection_tb.sv
